### rtl/adnp_pkg.sv
// ----------------------------------------------------------------------------
// adnp_pkg: shared types and constants of the ASCII decimal number parser
// Character codes, register indexes and the operation record that the
// classifier passes to the executing stage through the queue.
// ----------------------------------------------------------------------------
package adnp_pkg;

  localparam int unsigned CHAR_W = 8;
  localparam int unsigned FRAC_W = 5;
  localparam int unsigned DIGIT_W = 4;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2b;
  localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2e;
  localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;

  localparam logic [FRAC_W-1:0] FRAC_MAX = 5'd31;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_CHAR  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECIMAL_MODE = 1'b1;

  // queue between classifier and executing stage
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_DIGIT,
    OP_SIGN,
    OP_POINT,
    OP_TERM
  } op_e;

  typedef struct packed {
    op_e               kind;
    logic              minus;
    logic [DIGIT_W-1:0] digit;
  } op_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ignore_char;
    logic              decimal_mode;
  } cfg_t;

endpackage

### rtl/adnp_in_if.sv
// ----------------------------------------------------------------------------
// adnp_in_if: character input channel
// Valid/ready channel carrying one received character or an end-of-data mark.
// ----------------------------------------------------------------------------
interface adnp_in_if;

  logic                       valid;
  logic                       ready;
  logic [adnp_pkg::CHAR_W-1:0] ch;
  logic                       end_of_data;

  modport source (output valid, output ch, output end_of_data, input ready);
  modport sink   (input valid, input ch, input end_of_data, output ready);

endinterface

### rtl/adnp_out_if.sv
// ----------------------------------------------------------------------------
// adnp_out_if: parsed number output channel
// Valid/ready channel carrying one parsed number with its status flags.
// ----------------------------------------------------------------------------
interface adnp_out_if #(
  parameter int unsigned MAG_BITS = 31
);

  logic                       valid;
  logic                       ready;
  logic                       ok;
  logic                       negative;
  logic [MAG_BITS-1:0]        magnitude;
  logic [adnp_pkg::FRAC_W-1:0] frac_digits;
  logic                       overflow;

  modport source (
    output valid, output ok, output negative, output magnitude,
    output frac_digits, output overflow, input ready
  );
  modport sink (
    input valid, input ok, input negative, input magnitude,
    input frac_digits, input overflow, output ready
  );

endinterface

### rtl/ascii_decimal_number_parser.sv
// ----------------------------------------------------------------------------
// ascii_decimal_number_parser: streaming ASCII decimal number parser
// Builds signed decimal numbers from a character stream, one character a cycle while
// the queue has room, and reports each number with its sign, magnitude and fraction count.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one character (ch) or an end-of-data mark per transaction.
//   out_o carries one parsed number per terminator: ok, negative, magnitude,
//   frac_digits and overflow; value = magnitude * 10^-frac_digits.
//   Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i while
//   no transaction is in flight: index 0 sets the ignore character, index 1
//   the decimal mode.
// Timing:
//   One character per cycle while the queue has room. An accepted
//   terminator passes the two-entry queue, then the accumulator and its
//   output register, before its result shows on out_o.
// Reset:
//   rst_ni clears the queue, the number state, the configuration and
//   out_o.valid; no clearing pass is needed.
// Stall:
//   While out_o is stalled, digits, signs and points that finish nothing keep
//   executing; in_i.ready drops only when the queue fills behind a pending
//   operation that finishes a number.
// ----------------------------------------------------------------------------
module ascii_decimal_number_parser #(
  parameter int unsigned MAG_BITS = 31
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [adnp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [adnp_pkg::CHAR_W-1:0]        cfg_data_i,
  adnp_in_if.sink                            in_i,
  adnp_out_if.source                         out_o
);

  adnp_pkg::cfg_t cfg_q;
  logic           push;
  adnp_pkg::op_t  push_op;
  logic           pop;
  logic           head_valid;
  adnp_pkg::op_t  head_op;
  logic           full;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ignore_char  <= adnp_pkg::CHAR_NONE;
      cfg_q.decimal_mode <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        adnp_pkg::CFG_IGNORE_CHAR:  cfg_q.ignore_char  <= cfg_data_i;
        adnp_pkg::CFG_DECIMAL_MODE: cfg_q.decimal_mode <= cfg_data_i[0];
        default:                    cfg_q              <= cfg_q;
      endcase
    end
  end

  adnp_front u_front (
    .in_i   (in_i),
    .cfg_i  (cfg_q),
    .full_i (full),
    .push_o (push),
    .op_o   (push_op)
  );

  adnp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .op_i         (push_op),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_op_o    (head_op),
    .full_o       (full)
  );

  adnp_back #(
    .MAG_BITS (MAG_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_op_i    (head_op),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule

### rtl/adnp_front.sv
// ----------------------------------------------------------------------------
// adnp_front: character classifier
// Accepts characters, drops the ignore character (signs and end-of-data marks take priority) and turns every other
// transaction into an operation record for the queue.
// ----------------------------------------------------------------------------
module adnp_front (
  adnp_in_if.sink         in_i,
  input  adnp_pkg::cfg_t  cfg_i,
  input  logic            full_i,
  output logic            push_o,
  output adnp_pkg::op_t   op_o
);

  logic is_sign;
  logic is_ignore;
  logic is_digit;
  logic is_point;
  logic take;

  // accept whenever the queue has room
  assign in_i.ready = !full_i;
  assign take       = in_i.valid && !full_i;

  // classify the character on its own, without the number state
  assign is_sign   = (in_i.ch == adnp_pkg::CHAR_MINUS) || (in_i.ch == adnp_pkg::CHAR_PLUS);
  assign is_ignore = (cfg_i.ignore_char != adnp_pkg::CHAR_NONE) &&
                     (in_i.ch == cfg_i.ignore_char);
  assign is_point  = (in_i.ch == adnp_pkg::CHAR_POINT) && cfg_i.decimal_mode;
  assign is_digit  = (in_i.ch >= adnp_pkg::CHAR_ZERO) && (in_i.ch <= adnp_pkg::CHAR_NINE);

  // build the operation; ignored characters never enter the queue
  always_comb begin
    op_o.minus = (in_i.ch == adnp_pkg::CHAR_MINUS);
    op_o.digit = in_i.ch[adnp_pkg::DIGIT_W-1:0];
    push_o     = take;
    if (in_i.end_of_data) begin
      op_o.kind = adnp_pkg::OP_TERM;
    end else if (is_sign) begin
      op_o.kind = adnp_pkg::OP_SIGN;
    end else if (is_ignore) begin
      op_o.kind = adnp_pkg::OP_TERM;
      push_o    = 1'b0;
    end else if (is_point) begin
      op_o.kind = adnp_pkg::OP_POINT;
    end else if (is_digit) begin
      op_o.kind = adnp_pkg::OP_DIGIT;
    end else begin
      op_o.kind = adnp_pkg::OP_TERM;
    end
  end

endmodule

### rtl/adnp_queue.sv
// ----------------------------------------------------------------------------
// adnp_queue: operation queue
// Short first-in first-out buffer between the classifier and the executing
// stage, so that each side stalls on its own.
// ----------------------------------------------------------------------------
module adnp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  adnp_pkg::op_t  op_i,
  input  logic           pop_i,
  output logic           head_valid_o,
  output adnp_pkg::op_t  head_op_o,
  output logic           full_o
);

  localparam int unsigned PtrW = adnp_pkg::QUEUE_PTR_W;
  localparam int unsigned CntW = adnp_pkg::QUEUE_CNT_W;
  localparam logic [PtrW-1:0] LastPtr = PtrW'(adnp_pkg::QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(adnp_pkg::QUEUE_DEPTH);

  adnp_pkg::op_t   mem_q [adnp_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push;
  logic            do_pop;

  assign full_o       = (count_q == FullCnt);
  assign head_valid_o = (count_q != '0);
  assign head_op_o    = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  // advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // store the incoming operation
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= op_i;
    end
  end

endmodule

### rtl/adnp_back.sv
// ----------------------------------------------------------------------------
// adnp_back: number accumulator
// Executes queued operations against the number state, saturates the
// magnitude and fraction count, and holds each finished number in an
// output register until the receiver takes it.
// ----------------------------------------------------------------------------
module adnp_back #(
  parameter int unsigned MAG_BITS = 31
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           head_valid_i,
  input  adnp_pkg::op_t  head_op_i,
  output logic           pop_o,
  adnp_out_if.source     out_o
);

  localparam int unsigned WideW = MAG_BITS + 4;

  logic                        neg_q, neg_d;
  logic [MAG_BITS-1:0]         accum_q, accum_d;
  logic [adnp_pkg::FRAC_W-1:0] frac_q, frac_d;
  logic                        in_frac_q, in_frac_d;
  logic                        seen_q, seen_d;
  logic                        sat_q, sat_d;

  logic                        out_valid_q, out_valid_d;
  logic                        out_ok_q;
  logic                        out_neg_q;
  logic [MAG_BITS-1:0]         out_mag_q;
  logic [adnp_pkg::FRAC_W-1:0] out_frac_q;
  logic                        out_ovf_q;

  logic [WideW-1:0]            mac_w;
  logic                        mac_ovf;
  logic                        emit;
  logic                        slot_free;
  logic                        load;

  // accum * 10 + digit, with overflow taken from the top bits
  assign mac_w   = WideW'({accum_q, 3'b000}) + WideW'({accum_q, 1'b0}) +
                   WideW'(head_op_i.digit);
  assign mac_ovf = |mac_w[WideW-1:MAG_BITS];

  // decide whether the head operation finishes a number
  always_comb begin
    case (head_op_i.kind)
      adnp_pkg::OP_DIGIT: emit = 1'b0;
      adnp_pkg::OP_SIGN:  emit = seen_q;
      adnp_pkg::OP_POINT: emit = !(seen_q && !in_frac_q);
      adnp_pkg::OP_TERM:  emit = 1'b1;
      default:            emit = 1'b1;
    endcase
  end

  // hold the queue head while a result cannot be placed
  assign slot_free = !out_valid_q || out_o.ready;
  assign pop_o     = head_valid_i && (slot_free || !emit);
  assign load      = pop_o && emit;

  // update the number state
  always_comb begin
    neg_d     = neg_q;
    accum_d   = accum_q;
    frac_d    = frac_q;
    in_frac_d = in_frac_q;
    seen_d    = seen_q;
    sat_d     = sat_q;
    if (pop_o) begin
      if (emit) begin
        neg_d     = (head_op_i.kind == adnp_pkg::OP_SIGN) && head_op_i.minus;
        accum_d   = '0;
        frac_d    = '0;
        in_frac_d = 1'b0;
        seen_d    = 1'b0;
        sat_d     = 1'b0;
      end else begin
        case (head_op_i.kind)
          adnp_pkg::OP_SIGN: begin
            neg_d = neg_q || head_op_i.minus;
          end
          adnp_pkg::OP_POINT: begin
            in_frac_d = 1'b1;
          end
          adnp_pkg::OP_DIGIT: begin
            seen_d = 1'b1;
            if (mac_ovf) begin
              accum_d = '1;
              sat_d   = 1'b1;
            end else begin
              accum_d = mac_w[MAG_BITS-1:0];
            end
            if (in_frac_q) begin
              if (frac_q == adnp_pkg::FRAC_MAX) begin
                sat_d = 1'b1;
              end else begin
                frac_d = frac_q + 1'b1;
              end
            end
          end
          default: begin
            neg_d = neg_q;
          end
        endcase
      end
    end
  end

  // output valid: set on a finished number, drop once taken
  always_comb begin
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neg_q       <= 1'b0;
      accum_q     <= '0;
      frac_q      <= '0;
      in_frac_q   <= 1'b0;
      seen_q      <= 1'b0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      neg_q       <= neg_d;
      accum_q     <= accum_d;
      frac_q      <= frac_d;
      in_frac_q   <= in_frac_d;
      seen_q      <= seen_d;
      sat_q       <= sat_d;
      out_valid_q <= out_valid_d;
    end
  end

  // capture the finished number
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_ok_q   <= seen_q;
      out_neg_q  <= neg_q;
      out_mag_q  <= accum_q;
      out_frac_q <= frac_q;
      out_ovf_q  <= sat_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.ok          = out_ok_q;
  assign out_o.negative    = out_neg_q;
  assign out_o.magnitude   = out_mag_q;
  assign out_o.frac_digits = out_frac_q;
  assign out_o.overflow    = out_ovf_q;

endmodule

### rtl/adnp_checker.sv
// ----------------------------------------------------------------------------
// adnp_checker: port-level checks of the parser
// Watches the output channel of the top level over time.
// ----------------------------------------------------------------------------
module adnp_checker #(
  parameter int unsigned MAG_BITS = 31
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_ok,
  input logic                        out_negative,
  input logic [MAG_BITS-1:0]         out_magnitude,
  input logic [adnp_pkg::FRAC_W-1:0] out_frac_digits,
  input logic                        out_overflow
);

  // a stalled transaction holds its number
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_ok) &&
      $stable(out_negative) && $stable(out_magnitude) &&
      $stable(out_frac_digits) && $stable(out_overflow))
    else $error("out transaction changed while stalled");

  // a number without digits carries no magnitude, fraction or overflow
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ok |-> out_magnitude == '0 && out_frac_digits == '0 &&
      !out_overflow)
    else $error("empty number reports digits");

  // no result is offered in the cycle after a reset cycle
  assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid)
    else $error("out valid during reset");

endmodule

bind ascii_decimal_number_parser adnp_checker #(
  .MAG_BITS (MAG_BITS)
) u_adnp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid       (out_o.valid),
  .out_ready       (out_o.ready),
  .out_ok          (out_o.ok),
  .out_negative    (out_o.negative),
  .out_magnitude   (out_o.magnitude),
  .out_frac_digits (out_o.frac_digits),
  .out_overflow    (out_o.overflow)
);
